[src/mma_pkg.sv]
package mma_pkg;

  localparam logic [2:0] REQ_LOAD_LEFT  = 3'd0;
  localparam logic [2:0] REQ_LOAD_RIGHT = 3'd1;
  localparam logic [2:0] REQ_LOAD_ACC   = 3'd2;
  localparam logic [2:0] REQ_COMPUTE    = 3'd3;
  localparam logic [2:0] REQ_READ       = 3'd4;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam int unsigned DIM_W = 5;
  localparam int unsigned IDX_W = 4;

  localparam logic [1:0] CFG_ROWS  = 2'd0;
  localparam logic [1:0] CFG_INNER = 2'd1;
  localparam logic [1:0] CFG_COLS  = 2'd2;
  localparam logic [1:0] CFG_TRANS = 2'd3;

  typedef struct packed {
    logic [2:0]       req;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
  } cmd_hdr_t;

endpackage

[src/mma_front.sv]
module mma_front #(
  parameter int QW = 8,
  parameter int OW = 16,
  parameter int AW = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  mma_pkg::cmd_hdr_t   s_hdr,
  input  logic [OW-1:0]       s_opnd,
  input  logic [AW-1:0]       s_start,
  output logic                q_valid,
  input  logic                q_ready,
  output mma_pkg::cmd_hdr_t   q_hdr,
  output logic [OW-1:0]       q_opnd,
  output logic [AW-1:0]       q_start
);

  localparam int PW = $clog2(QW);
  localparam int DW = OW + AW + $bits(mma_pkg::cmd_hdr_t);

  logic [DW-1:0] mem [QW];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW:0]   cnt;
  logic          push;
  logic          pop;
  logic          known;

  assign known = (s_hdr.req == mma_pkg::REQ_LOAD_LEFT) || (s_hdr.req == mma_pkg::REQ_LOAD_RIGHT)
              || (s_hdr.req == mma_pkg::REQ_LOAD_ACC) || (s_hdr.req == mma_pkg::REQ_COMPUTE)
              || (s_hdr.req == mma_pkg::REQ_READ);
  assign s_tready = (cnt != (PW+1)'(QW));
  assign push = s_tvalid && s_tready && known;
  assign q_valid = (cnt != '0);
  assign pop = q_valid && q_ready;
  assign {q_hdr, q_opnd, q_start} = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= {s_hdr, s_opnd, s_start};
    end
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

[src/mma_back.sv]
module mma_back #(
  parameter int MAX_DIM = 16,
  parameter int OW = 16,
  parameter int AW = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  mma_pkg::cmd_hdr_t   q_hdr,
  input  logic [OW-1:0]       q_opnd,
  input  logic [AW-1:0]       q_start,
  input  logic [mma_pkg::DIM_W-1:0] cfg_rows,
  input  logic [mma_pkg::DIM_W-1:0] cfg_inner,
  input  logic [mma_pkg::DIM_W-1:0] cfg_cols,
  input  logic                cfg_trans,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic                m_kind,
  output logic [AW-1:0]       m_value,
  output logic                m_sat
);

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int MW = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
  localparam int PRW = 2 * OW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLR   = 3'd1;
  localparam logic [2:0] ST_RDACC = 3'd2;
  localparam logic [2:0] ST_MAC   = 3'd3;
  localparam logic [2:0] ST_WB    = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;

  logic [OW-1:0] lmem [DEPTH];
  logic [OW-1:0] rmem [DEPTH];
  logic [AW-1:0] amem [DEPTH];

  logic [2:0]    state;
  logic [MW:0]   clr;
  logic [IW:0]   r, c, k;
  logic [IW:0]   rows, inner, cols;
  logic          sat;
  logic [AW-1:0] acc;
  logic [AW-1:0] acc_rd;
  logic [OW-1:0] a_rd, b_rd;
  logic          mac_v;
  logic          mac_last;
  logic [PRW-1:0] prod;
  logic          prod_v, prod_last;
  logic          in_range;
  logic [MW-1:0] q_addr;

  function automatic logic [IW:0] clip(input logic [mma_pkg::DIM_W-1:0] d);
    if (32'(d) > MAX_DIM) return (IW+1)'(MAX_DIM);
    return (IW+1)'(d);
  endfunction

  function automatic logic [MW-1:0] addr(input logic [IW:0] i, input logic [IW:0] j);
    return MW'(32'(i) * MAX_DIM + 32'(j));
  endfunction

  assign in_range = (32'(q_hdr.first_index) < MAX_DIM) && (32'(q_hdr.second_index) < MAX_DIM);
  assign q_addr = addr((IW+1)'(q_hdr.first_index), (IW+1)'(q_hdr.second_index));
  assign q_ready = (state == ST_IDLE) && !m_tvalid;

  logic [AW:0] sum;
  logic [AW-1:0] pext;
  logic [AW-1:0] amax, amin;
  assign amax = {1'b0, {(AW-1){1'b1}}};
  assign amin = {1'b1, {(AW-1){1'b0}}};
  assign pext = (AW >= PRW) ? AW'($signed(prod)) : prod[AW-1:0];
  assign sum = {acc[AW-1], acc} + {pext[AW-1], pext};

  always_ff @(posedge clk) begin
    a_rd <= cfg_trans ? lmem[addr(k, r)] : lmem[addr(r, k)];
    b_rd <= rmem[addr(k, c)];
    acc_rd <= amem[(state == ST_READ || state == ST_IDLE) ? q_addr : addr(r, c)];
    prod <= PRW'($signed(a_rd) * $signed(b_rd));
    if (q_valid && q_ready && in_range) begin
      if (q_hdr.req == mma_pkg::REQ_LOAD_LEFT) lmem[q_addr] <= q_opnd;
      if (q_hdr.req == mma_pkg::REQ_LOAD_RIGHT) rmem[q_addr] <= q_opnd;
      if (q_hdr.req == mma_pkg::REQ_LOAD_ACC) amem[q_addr] <= q_start;
    end
    if (state == ST_CLR) amem[clr[MW-1:0]] <= '0;
    if (state == ST_WB) amem[addr(r, c)] <= acc;
    if (rst) begin
      state <= ST_CLR;
      clr <= '0;
      m_tvalid <= 1'b0;
      sat <= 1'b0;
      mac_v <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      prod_v <= mac_v;
      prod_last <= mac_last;
      case (state)
        ST_CLR: begin
          clr <= clr + 1'b1;
          if (32'(clr) == DEPTH - 1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid && q_ready) begin
            if (q_hdr.req == mma_pkg::REQ_COMPUTE) begin
              sat <= 1'b0;
              rows <= clip(cfg_rows);
              inner <= clip(cfg_inner);
              cols <= clip(cfg_cols);
              r <= '0;
              c <= '0;
              k <= '0;
              if (cfg_rows == '0 || cfg_cols == '0 || cfg_inner == '0) begin
                m_tvalid <= 1'b1;
                m_kind <= mma_pkg::KIND_DONE;
                m_value <= '0;
                m_sat <= 1'b0;
              end else begin
                state <= ST_RDACC;
              end
            end else if (q_hdr.req == mma_pkg::REQ_READ) begin
              m_value <= in_range ? '1 : '0;
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          m_tvalid <= 1'b1;
          m_kind <= mma_pkg::KIND_READ;
          m_value <= m_value & acc_rd;
          m_sat <= sat;
          state <= ST_IDLE;
        end
        ST_RDACC: begin
          state <= ST_MAC;
          mac_v <= 1'b0;
          k <= '0;
        end
        ST_MAC: begin
          if (k == '0 && !mac_v && !prod_v) acc <= acc_rd;
          if (!mac_last && (mac_v || (!prod_v && k == '0)) && (k + 1'b1 != inner)) begin
            k <= k + 1'b1;
          end
          if (mac_v) begin
            mac_v <= !mac_last;
          end else if (!prod_v && !mac_last) begin
            mac_v <= 1'b1;
          end
          if (prod_v) begin
            if (!sum[AW] && sum[AW-1]) begin
              acc <= amax;
              sat <= 1'b1;
            end else if (sum[AW] && !sum[AW-1]) begin
              acc <= amin;
              sat <= 1'b1;
            end else begin
              acc <= sum[AW-1:0];
            end
            if (prod_last) state <= ST_WB;
          end
        end
        ST_WB: begin
          k <= '0;
          if (c + 1'b1 == cols) begin
            c <= '0;
            if (r + 1'b1 == rows) begin
              r <= '0;
              m_tvalid <= 1'b1;
              m_kind <= mma_pkg::KIND_DONE;
              m_value <= '0;
              m_sat <= sat;
              state <= ST_IDLE;
            end else begin
              r <= r + 1'b1;
              state <= ST_RDACC;
            end
          end else begin
            c <= c + 1'b1;
            state <= ST_RDACC;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // index stepping for operand reads runs one k per cycle in mac state
  always_ff @(posedge clk) begin
    if (rst) begin
      mac_last <= 1'b0;
    end else if (state == ST_RDACC) begin
      mac_last <= 1'b0;
    end else if (state == ST_MAC && !mac_last && (mac_v || (!prod_v && k == '0))) begin
      if (k + 1'b1 == inner) mac_last <= 1'b1;
    end
  end

endmodule

[src/matrix_multiply_accumulate.sv]
// channel  dir  tdata (low bit up)                               tuser/tlast
// s_axis   in   req_type, first_index, second_index,             -
//               operand_value, start_value (80 bits)
// m_axis   out  result_value, saturated (56 bits)                reply_kind
// cfg      in   cfg_we, cfg_index, cfg_data                      -
// a load is written as the back end takes it, a read replies via ST_READ plus the output handshake
// compute runs RDACC, MAC, WB per element, one multiply-accumulate per cycle within an element
// after reset the accumulator store is cleared entry by entry; requests queue but none runs
// the input queue keeps taking requests while the back end is busy or the output stalls, until full
module matrix_multiply_accumulate #(
  parameter int MAX_DIM = 16,
  parameter int OPERAND_WIDTH = 16,
  parameter int ACC_WIDTH = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [OPERAND_WIDTH+ACC_WIDTH+11+((8-((OPERAND_WIDTH+ACC_WIDTH+11)%8))%8)-1:0]
                       s_axis_tdata, // req_type, first_index, second_index, operand_value, start_value
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [ACC_WIDTH+1+((8-((ACC_WIDTH+1)%8))%8)-1:0]
                       m_axis_tdata, // result_value, saturated
  output logic         m_axis_tuser, // reply_kind
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [4:0]   cfg_data
);

  localparam int OW = OPERAND_WIDTH;
  localparam int AW = ACC_WIDTH;

  logic [mma_pkg::DIM_W-1:0] rows, inner, cols;
  logic trans;
  mma_pkg::cmd_hdr_t s_hdr, q_hdr;
  logic q_valid, q_ready;
  logic [OW-1:0] q_opnd;
  logic [AW-1:0] q_start, value;
  logic sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= 5'd16;
      inner <= 5'd16;
      cols <= 5'd16;
      trans <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mma_pkg::CFG_ROWS: rows <= cfg_data;
        mma_pkg::CFG_INNER: inner <= cfg_data;
        mma_pkg::CFG_COLS: cols <= cfg_data;
        mma_pkg::CFG_TRANS: trans <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s_hdr.req = s_axis_tdata[2:0];
  assign s_hdr.first_index = s_axis_tdata[6:3];
  assign s_hdr.second_index = s_axis_tdata[10:7];

  mma_front #(.QW(4), .OW(OW), .AW(AW)) u_front (
    .clk, .rst,
    .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready), .s_hdr(s_hdr),
    .s_opnd(s_axis_tdata[11 +: OW]), .s_start(s_axis_tdata[11+OW +: AW]),
    .q_valid, .q_ready, .q_hdr, .q_opnd, .q_start
  );

  mma_back #(.MAX_DIM(MAX_DIM), .OW(OW), .AW(AW)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_hdr, .q_opnd, .q_start,
    .cfg_rows(rows), .cfg_inner(inner), .cfg_cols(cols), .cfg_trans(trans),
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_kind(m_axis_tuser),
    .m_value(value), .m_sat(sat)
  );

  assign m_axis_tdata = $bits(m_axis_tdata)'({sat, value});

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> value == '0)
    else $error("done reply carries data");
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !q_ready)
    else $error("back end took request with result pending");

endmodule

[tb/tb_matrix_multiply_accumulate.sv]
`timescale 1ns / 1ps

module tb_matrix_multiply_accumulate;

  localparam int DIM = 16;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [2:0] REQ_RSVD_A = 3'd5;
  localparam logic [2:0] REQ_RSVD_B = 3'd6;
  localparam logic [2:0] REQ_RSVD_C = 3'd7;
  localparam logic [47:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] ACC_MIN = 48'h8000_0000_0000;
  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;

  typedef struct packed {
    logic [2:0]  req;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [15:0] operand;
    logic [47:0] start;
  } mma_req_t;

  typedef struct packed {
    logic        kind;
    logic [47:0] value;
    logic        sat;
  } mma_reply_t;

  typedef struct packed {
    mma_req_t   rq;
    logic       typed;
    mma_reply_t rep;
  } dir_row_t;

  typedef struct packed {
    logic [4:0] rows;
    logic [4:0] inner;
    logic [4:0] cols;
    logic       trans;
  } shape_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;

  matrix_multiply_accumulate dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  longint left_mem[DIM*DIM];
  longint right_mem[DIM*DIM];
  longint acc_mem[DIM*DIM];
  bit left_written[DIM*DIM];
  bit right_written[DIM*DIM];
  bit sat_flag;
  shape_t shape;

  mma_reply_t pending_replies[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int rx_left = 0;
  int rx_mode = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int eff(input logic [4:0] d);
    return (d > DIM) ? DIM : int'(d);
  endfunction

  function automatic longint sat_sum(input longint acc, input longint p);
    if (p > 0 && acc > ACC_HI - p) begin
      sat_flag = 1;
      return ACC_HI;
    end
    if (p < 0 && acc < ACC_LO - p) begin
      sat_flag = 1;
      return ACC_LO;
    end
    return acc + p;
  endfunction

  task automatic gemm_apply(input mma_req_t rq, output bit got, output mma_reply_t rep);
    int a;
    longint acc;
    longint lv;
    a = rq.row * DIM + rq.col;
    got = 0;
    rep = '0;
    case (rq.req)
      mma_pkg::REQ_LOAD_LEFT: begin
        left_mem[a] = longint'($signed(rq.operand));
        left_written[a] = 1;
      end
      mma_pkg::REQ_LOAD_RIGHT: begin
        right_mem[a] = longint'($signed(rq.operand));
        right_written[a] = 1;
      end
      mma_pkg::REQ_LOAD_ACC: acc_mem[a] = longint'($signed(rq.start));
      mma_pkg::REQ_COMPUTE: begin
        sat_flag = 0;
        for (int r = 0; r < eff(shape.rows); r++)
          for (int c = 0; c < eff(shape.cols); c++) begin
            acc = acc_mem[r*DIM+c];
            for (int k = 0; k < eff(shape.inner); k++) begin
              lv = shape.trans ? left_mem[k*DIM+r] : left_mem[r*DIM+k];
              acc = sat_sum(acc, lv * right_mem[k*DIM+c]);
            end
            acc_mem[r*DIM+c] = acc;
          end
        got = 1;
        rep = '{mma_pkg::KIND_DONE, 48'd0, sat_flag};
      end
      mma_pkg::REQ_READ: begin
        got = 1;
        rep = '{mma_pkg::KIND_READ, acc_mem[a][47:0], sat_flag};
      end
      default: ;
    endcase
  endtask

  task automatic send_req(input mma_req_t rq, input bit typed, input mma_reply_t typed_rep);
    bit got;
    mma_reply_t rep;
    int gap;
    @(negedge clk);
    s_axis_tdata <= {5'd0, rq.start, rq.operand, rq.col, rq.row, rq.req};
    s_axis_tvalid <= 1;
    do @(posedge clk); while (!s_axis_tready);
    gemm_apply(rq, got, rep);
    if (got) pending_replies.push_back(typed ? typed_rep : rep);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid <= 0;
        repeat (gap - 1) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send(input mma_req_t rq);
    send_req(rq, 0, '0);
  endtask

  task automatic drain(input int settle);
    @(negedge clk);
    s_axis_tvalid <= 0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_shape(input shape_t s);
    write_reg(mma_pkg::CFG_ROWS, s.rows);
    write_reg(mma_pkg::CFG_INNER, s.inner);
    write_reg(mma_pkg::CFG_COLS, s.cols);
    write_reg(mma_pkg::CFG_TRANS, {4'd0, s.trans});
    shape = s;
  endtask

  function automatic mma_req_t mk(input logic [2:0] req, input int r, input int c,
                                  input logic [15:0] op, input logic [47:0] st);
    mma_req_t rq;
    rq = '{req, r[3:0], c[3:0], op, st};
    return rq;
  endfunction

  function automatic int pick(input int d);
    if (d == 0 || $urandom_range(0, 3) == 0) return $urandom_range(0, DIM-1);
    return $urandom_range(0, d-1);
  endfunction

  function automatic logic [15:0] rnd_operand();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] rnd_start();
    case ($urandom_range(0, 5))
      0: return ACC_MAX - 48'($urandom_range(0, 1 << 30));
      1: return ACC_MIN + 48'($urandom_range(0, 1 << 30));
      2: return 48'({$urandom, $urandom});
      default: return 48'($signed(24'($urandom)));
    endcase
  endfunction

  // make sure a pass never touches an operand entry that was never loaded
  task automatic fill_operands();
    int a;
    for (int r = 0; r < eff(shape.rows); r++)
      for (int k = 0; k < eff(shape.inner); k++) begin
        a = shape.trans ? k*DIM + r : r*DIM + k;
        if (!left_written[a])
          send(mk(mma_pkg::REQ_LOAD_LEFT, a / DIM, a % DIM, rnd_operand(), '0));
      end
    for (int k = 0; k < eff(shape.inner); k++)
      for (int c = 0; c < eff(shape.cols); c++)
        if (!right_written[k*DIM+c])
          send(mk(mma_pkg::REQ_LOAD_RIGHT, k, c, rnd_operand(), '0));
  endtask

  task automatic random_phase(input int count, input bit pause_mid);
    int sel;
    int rows, inner, cols;
    logic [2:0] rsvd;
    rows = eff(shape.rows);
    inner = eff(shape.inner);
    cols = eff(shape.cols);
    for (int n = 0; n < count; n++) begin
      if (pause_mid && n == count / 2) drain(0);
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        if (shape.trans)
          send(mk(mma_pkg::REQ_LOAD_LEFT, pick(inner), pick(rows), rnd_operand(),
                  48'($urandom)));
        else
          send(mk(mma_pkg::REQ_LOAD_LEFT, pick(rows), pick(inner), rnd_operand(),
                  48'($urandom)));
      end else if (sel < 58) begin
        send(mk(mma_pkg::REQ_LOAD_RIGHT, pick(inner), pick(cols), rnd_operand(),
                48'($urandom)));
      end else if (sel < 72) begin
        send(mk(mma_pkg::REQ_LOAD_ACC, pick(rows), pick(cols), 16'($urandom), rnd_start()));
      end else if (sel < 93) begin
        send(mk(mma_pkg::REQ_READ, pick(rows), pick(cols), 16'($urandom), 48'($urandom)));
      end else if (sel < 97) begin
        fill_operands();
        send(mk(mma_pkg::REQ_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15),
                16'($urandom), 48'($urandom)));
      end else begin
        rsvd = 3'($urandom_range(REQ_RSVD_A, REQ_RSVD_C));
        send(mk(rsvd, $urandom_range(0, 15), $urandom_range(0, 15),
                16'($urandom), 48'($urandom)));
      end
    end
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(1, 60);
    end else begin
      rx_left = rx_left - 1;
    end
    case (rx_mode)
      0: m_axis_tready <= 1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= (rx_left % 8 == 0);
    endcase
  end

  always @(posedge clk) begin
    mma_reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply kind=%0b value=%h sat=%0b", $time,
                 m_axis_tuser, m_axis_tdata[47:0], m_axis_tdata[48]);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $display("%0t: kind expected %0b actual %0b", $time, want.kind, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[47:0] !== want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, m_axis_tdata[47:0]);
          errors++;
        end
        if (m_axis_tdata[48] !== want.sat) begin
          $display("%0t: saturated expected %0b actual %0b", $time, want.sat,
                   m_axis_tdata[48]);
          errors++;
        end
      end
    end
  end

  dir_row_t dir_rows[$];
  shape_t shapes[$];

  initial begin
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    m_axis_tready = 0;
    cfg_we = 0;
    cfg_index = mma_pkg::CFG_ROWS;
    cfg_data = '0;
    for (int a = 0; a < DIM*DIM; a++) begin
      left_mem[a] = 0;
      right_mem[a] = 0;
      acc_mem[a] = 0;
      left_written[a] = 0;
      right_written[a] = 0;
    end
    sat_flag = 0;
    shape = '{5'd16, 5'd16, 5'd16, 1'b0};

    dir_rows = '{
      '{mk(mma_pkg::REQ_READ, 0, 0, 16'h0, 48'h0), 1'b1,
        '{mma_pkg::KIND_READ, 48'h0, 1'b0}},
      '{mk(mma_pkg::REQ_READ, 15, 15, 16'hFFFF, ACC_MAX), 1'b1,
        '{mma_pkg::KIND_READ, 48'h0, 1'b0}},
      '{mk(mma_pkg::REQ_LOAD_LEFT, 0, 0, 16'h8000, 48'h0), 1'b0, '0},
      '{mk(mma_pkg::REQ_LOAD_RIGHT, 0, 0, 16'h8000, 48'h0), 1'b0, '0},
      '{mk(mma_pkg::REQ_LOAD_ACC, 0, 0, 16'h0, ACC_MAX), 1'b0, '0},
      '{mk(mma_pkg::REQ_COMPUTE, 0, 0, 16'h0, 48'h0), 1'b1,
        '{mma_pkg::KIND_DONE, 48'h0, 1'b1}},
      '{mk(mma_pkg::REQ_READ, 0, 0, 16'h0, 48'h0), 1'b1,
        '{mma_pkg::KIND_READ, ACC_MAX, 1'b1}},
      '{mk(mma_pkg::REQ_LOAD_ACC, 0, 0, 16'h0, ACC_MIN), 1'b0, '0},
      '{mk(mma_pkg::REQ_LOAD_RIGHT, 0, 0, 16'h7FFF, 48'h0), 1'b0, '0},
      '{mk(mma_pkg::REQ_COMPUTE, 15, 15, 16'hFFFF, ACC_MAX), 1'b1,
        '{mma_pkg::KIND_DONE, 48'h0, 1'b1}},
      '{mk(mma_pkg::REQ_READ, 0, 0, 16'h0, 48'h0), 1'b1,
        '{mma_pkg::KIND_READ, ACC_MIN, 1'b1}},
      '{mk(REQ_RSVD_A, 0, 0, 16'h1, 48'h1), 1'b0, '0},
      '{mk(REQ_RSVD_B, 15, 0, 16'h0, 48'h0), 1'b0, '0},
      '{mk(REQ_RSVD_C, 0, 15, 16'hFFFF, ACC_MAX), 1'b0, '0},
      '{mk(mma_pkg::REQ_LOAD_ACC, 15, 15, 16'h0, 48'h1234_5678_9ABC), 1'b0, '0},
      '{mk(mma_pkg::REQ_READ, 15, 15, 16'h0, 48'h0), 1'b1,
        '{mma_pkg::KIND_READ, 48'h1234_5678_9ABC, 1'b1}},
      '{mk(mma_pkg::REQ_LOAD_LEFT, 0, 0, 16'h0100, 48'h0), 1'b0, '0},
      '{mk(mma_pkg::REQ_LOAD_RIGHT, 0, 0, 16'h0100, 48'h0), 1'b0, '0},
      '{mk(mma_pkg::REQ_LOAD_ACC, 0, 0, 16'h0, 48'h0), 1'b0, '0},
      '{mk(mma_pkg::REQ_COMPUTE, 0, 0, 16'h0, 48'h0), 1'b1,
        '{mma_pkg::KIND_DONE, 48'h0, 1'b0}},
      '{mk(mma_pkg::REQ_READ, 0, 0, 16'h0, 48'h0), 1'b1,
        '{mma_pkg::KIND_READ, 48'h1_0000, 1'b0}},
      '{mk(mma_pkg::REQ_LOAD_ACC, 0, 1, 16'h0, 48'h0), 1'b0, '0},
      '{mk(mma_pkg::REQ_READ, 0, 1, 16'h0, 48'h0), 1'b0, '0}
    };

    shapes = '{
      '{5'd2, 5'd3, 5'd4, 1'b1}, '{5'd16, 5'd1, 5'd1, 1'b0}, '{5'd1, 5'd16, 5'd1, 1'b1},
      '{5'd1, 5'd1, 5'd16, 1'b0}, '{5'd0, 5'd3, 5'd2, 1'b0}, '{5'd3, 5'd0, 5'd2, 1'b1},
      '{5'd31, 5'd2, 5'd1, 1'b0}, '{5'd2, 5'd31, 5'd2, 1'b1}, '{5'd16, 5'd16, 5'd16, 1'b1},
      '{5'd4, 5'd4, 5'd4, 1'b0}, '{5'd3, 5'd5, 5'd2, 1'b1}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    set_shape('{5'd1, 5'd1, 5'd1, 1'b0});
    foreach (dir_rows[n]) send_req(dir_rows[n].rq, dir_rows[n].typed, dir_rows[n].rep);
    drain(SETTLE_CYCLES);

    foreach (shapes[p]) begin
      set_shape(shapes[p]);
      random_phase(110, p == 1);
      send(mk(mma_pkg::REQ_READ, 0, 0, 16'h0, 48'h0));
      drain(SETTLE_CYCLES);
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
src/mma_pkg.sv
src/mma_front.sv
src/mma_back.sv
src/matrix_multiply_accumulate.sv
tb/tb_matrix_multiply_accumulate.sv
